>>> hw/rtl/ltinv_pkg.sv
// ----------------------------------------------------------------------------
// ltinv_pkg
// Shared widths, constants and interface structs of the lower-triangular
// matrix inverter.
// ----------------------------------------------------------------------------
package ltinv_pkg;

  localparam int unsigned MaxSize = 8;
  localparam int unsigned IdxW    = 3;              // row or column index
  localparam int unsigned AddrW   = 2 * IdxW;       // row * MaxSize + column
  localparam int unsigned DataW   = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned SizeW   = 4;

  // Write port of the matrix store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } mem_wr_t;

  // Request to the divider: quotient of a Q32.32 value by a Q16.16 value.
  typedef struct packed {
    logic                    start;
    logic signed [AccW-1:0]  dividend;
    logic signed [DataW-1:0] divisor;
  } div_req_t;

endpackage

>>> hw/rtl/ltinv_mem.sv
// ----------------------------------------------------------------------------
// ltinv_mem
// Matrix store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ltinv_mem import ltinv_pkg::*; (
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  logic [AddrW-1:0] rd_a_addr_i,
  input  logic [AddrW-1:0] rd_b_addr_i,
  output logic [DataW-1:0] rd_a_data_o,
  output logic [DataW-1:0] rd_b_data_o
);

  logic [DataW-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_data_o <= mem_q[rd_a_addr_i];
    rd_b_data_o <= mem_q[rd_b_addr_i];
  end

endmodule

>>> hw/rtl/ltinv_div.sv
// ----------------------------------------------------------------------------
// ltinv_div
// Signed restoring divider, one quotient bit per cycle. Truncates toward
// zero and saturates the quotient to 32 bits signed.
// ----------------------------------------------------------------------------
module ltinv_div import ltinv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DataW-1:0] result_o
);

  localparam int unsigned CntW = $clog2(AccW);

  logic              run_q;
  logic [CntW-1:0]   cnt_q;
  logic [AccW-1:0]   quo_q;
  logic [DataW-1:0]  rem_q;
  logic [DataW-1:0]  dvs_q;
  logic              neg_q;
  logic [DataW:0]    trial;
  logic              fits;
  logic [AccW-1:0]   quo_d;
  logic [DataW-1:0]  rem_d;
  logic [DataW-1:0]  res_d;

  always_comb begin
    trial = {rem_q, quo_q[AccW-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? DataW'(trial - {1'b0, dvs_q}) : trial[DataW-1:0];
    quo_d = {quo_q[AccW-2:0], fits};
    // Final saturation of the magnitude with its sign.
    if (neg_q) begin
      if (quo_d > {{(AccW-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}}) begin
        res_d = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        res_d = DataW'(-quo_d[DataW-1:0]);
      end
    end else begin
      if (quo_d > {{(AccW-DataW+1){1'b0}}, {(DataW-1){1'b1}}}) begin
        res_d = {1'b0, {(DataW-1){1'b1}}};
      end else begin
        res_d = quo_d[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(AccW - 1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend[AccW-1] ? AccW'(-req_i.dividend) : req_i.dividend;
      dvs_q <= req_i.divisor[DataW-1] ? DataW'(-req_i.divisor) : req_i.divisor;
      neg_q <= req_i.dividend[AccW-1] ^ req_i.divisor[DataW-1];
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (cnt_q == CntW'(AccW - 1)) begin
        result_o <= res_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !run_q)
    else $error("divider started while running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !run_q)
    else $error("divider done while still running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> run_q)
    else $error("divider did not begin");

endmodule

>>> hw/rtl/lower_triangular_inverse.sv
// ----------------------------------------------------------------------------
// lower_triangular_inverse
// Loads an n x n Q16.16 matrix row by row, inverts its lower triangle in
// place by forward substitution and streams the matrix back out.
//
//   Channel   Direction  Signals
//   config    in         cfg_we_i, cfg_data_i
//   element   in         start, busy, element_value_i
//   result    out        result_strobe_o, result_value_o, zero_pivot_o,
//                        last_of_matrix_o
//
// Elements are accepted while the block is idle. After the final element the
// block is busy for the inversion: per column it reads the diagonal, starts
// the division and writes the reciprocal; per entry below it, it reads the
// pivot, subtracts one product term at a time, drains the products, starts the
// division and writes the quotient. A zero pivot skips the division, writes
// zero and raises zero_pivot_o. A closing step ends each column. The divider
// sets the pace. The n*n results then leave at one per cycle. Reset leaves
// the store unwritten and needs no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
module lower_triangular_inverse import ltinv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [SizeW-1:0]        cfg_data_i,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DataW-1:0] element_value_i,
  output logic                    result_strobe_o,
  output logic signed [DataW-1:0] result_value_o,
  output logic                    zero_pivot_o,
  output logic                    last_of_matrix_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_RDIAG   = 10'b0000000010,
    S_DDIV    = 10'b0000000100,
    S_DWAIT   = 10'b0000001000,
    S_ROW     = 10'b0000010000,
    S_ROWDIAG = 10'b0000100000,
    S_MAC     = 10'b0001000000,
    S_DRAIN   = 10'b0010000000,
    S_QWAIT   = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] AccMin = -AccMax;

  state_e                   state_q, state_d;
  logic [SizeW-1:0]         size_q;
  logic [SizeW-1:0]         n;
  logic [IdxW-1:0]          nm1;
  logic [IdxW-1:0]          lr_q, lc_q, or_q, oc_q;
  logic [SizeW-1:0]         i_q, j_q, k_q;
  logic                     err_q;
  logic [DataW-1:0]         dv_q;
  logic                     rv_q, pv_q;
  logic signed [AccW-1:0]   prod_q, acc_q;
  logic signed [AccW:0]     diff;
  logic                     ov_q, olast_q;
  logic                     load_last, out_last, accept;
  mem_wr_t                  wr;
  logic [AddrW-1:0]         ra_addr, rb_addr;
  logic [DataW-1:0]         ra_data, rb_data;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DataW-1:0]         div_res;

  always_comb begin
    if (size_q == '0) begin
      n = SizeW'(1);
    end else if (size_q > SizeW'(MaxSize)) begin
      n = SizeW'(MaxSize);
    end else begin
      n = size_q;
    end
    nm1 = IdxW'(n - 1'b1);
  end

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign load_last = (lr_q == nm1) && (lc_q == nm1);
  assign out_last  = (or_q == nm1) && (oc_q == nm1);
  assign diff      = {acc_q[AccW-1], acc_q} - {prod_q[AccW-1], prod_q};

  // Memory addressing, write selection and divider requests per state.
  always_comb begin
    state_d          = state_q;
    wr               = '0;
    ra_addr          = '0;
    rb_addr          = {k_q[IdxW-1:0], j_q[IdxW-1:0]};
    div_req.start    = 1'b0;
    div_req.dividend = acc_q;
    div_req.divisor  = $signed(dv_q);
    unique case (state_q)
      S_IDLE: begin
        wr.en   = accept;
        wr.addr = {lr_q, lc_q};
        wr.data = element_value_i;
        if (accept && load_last) state_d = S_RDIAG;
      end
      S_RDIAG: begin
        ra_addr = {j_q[IdxW-1:0], j_q[IdxW-1:0]};
        state_d = S_DDIV;
      end
      S_DDIV: begin
        wr.addr = {j_q[IdxW-1:0], j_q[IdxW-1:0]};
        if (ra_data == '0) begin
          wr.en   = 1'b1;
          state_d = S_ROW;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = AccW'(64'sh1_0000_0000);
          div_req.divisor  = $signed(ra_data);
          state_d          = S_DWAIT;
        end
      end
      S_DWAIT: begin
        wr.addr = {j_q[IdxW-1:0], j_q[IdxW-1:0]};
        wr.data = div_res;
        wr.en   = div_done;
        if (div_done) state_d = S_ROW;
      end
      S_ROW: begin
        ra_addr = {i_q[IdxW-1:0], i_q[IdxW-1:0]};
        if (i_q >= n) begin
          state_d = (j_q + 1'b1 >= n) ? S_OUT : S_RDIAG;
        end else begin
          state_d = S_ROWDIAG;
        end
      end
      S_ROWDIAG: state_d = S_MAC;
      S_MAC: begin
        ra_addr = {i_q[IdxW-1:0], k_q[IdxW-1:0]};
        if (k_q == i_q - 1'b1) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        wr.addr = {i_q[IdxW-1:0], j_q[IdxW-1:0]};
        if (!rv_q && !pv_q) begin
          if (dv_q == '0) begin
            wr.en   = 1'b1;
            state_d = S_ROW;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_QWAIT;
          end
        end
      end
      S_QWAIT: begin
        wr.addr = {i_q[IdxW-1:0], j_q[IdxW-1:0]};
        wr.data = div_res;
        wr.en   = div_done;
        if (div_done) state_d = S_ROW;
      end
      S_OUT: begin
        ra_addr = {or_q, oc_q};
        if (out_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= SizeW'(MaxSize);
      lr_q    <= '0;
      lc_q    <= '0;
      or_q    <= '0;
      oc_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      err_q   <= 1'b0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == S_MAC);
      pv_q    <= rv_q;
      ov_q    <= (state_q == S_OUT);
      olast_q <= (state_q == S_OUT) && out_last;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
        lr_q   <= '0;
        lc_q   <= '0;
      end else if (accept) begin
        if (lc_q == nm1) begin
          lc_q <= '0;
          lr_q <= load_last ? '0 : lr_q + 1'b1;
        end else begin
          lc_q <= lc_q + 1'b1;
        end
        if (load_last) begin
          err_q <= 1'b0;
          j_q   <= '0;
        end
      end
      unique case (state_q)
        S_DDIV: begin
          if (ra_data == '0) err_q <= 1'b1;
          i_q <= j_q + 1'b1;
        end
        S_ROW: begin
          if (i_q >= n) begin
            j_q  <= j_q + 1'b1;
            or_q <= '0;
            oc_q <= '0;
          end
        end
        S_ROWDIAG: k_q <= j_q;
        S_MAC: k_q <= k_q + 1'b1;
        S_DRAIN: begin
          if (!rv_q && !pv_q && dv_q == '0) begin
            err_q <= 1'b1;
            i_q   <= i_q + 1'b1;
          end
        end
        S_QWAIT: if (div_done) i_q <= i_q + 1'b1;
        S_OUT: begin
          if (oc_q == nm1) begin
            oc_q <= '0;
            or_q <= or_q + 1'b1;
          end else begin
            oc_q <= oc_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: pivot, product and saturating accumulator.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROWDIAG) begin
      dv_q  <= ra_data;
      acc_q <= '0;
    end else if (pv_q) begin
      if (diff > AccMax) begin
        acc_q <= AccW'(AccMax);
      end else if (diff < AccMin) begin
        acc_q <= AccW'(AccMin);
      end else begin
        acc_q <= diff[AccW-1:0];
      end
    end
    if (rv_q) begin
      prod_q <= $signed(ra_data) * $signed(rb_data);
    end
  end

  ltinv_mem u_mem (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_a_addr_i (ra_addr),
    .rd_b_addr_i (rb_addr),
    .rd_a_data_o (ra_data),
    .rd_b_data_o (rb_data)
  );

  ltinv_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .done_o   (div_done),
    .result_o (div_res)
  );

  assign result_strobe_o  = ov_q;
  assign result_value_o   = $signed(ra_data);
  assign zero_pivot_o     = err_q;
  assign last_of_matrix_o = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) result_strobe_o |-> $past(busy))
    else $error("result transfer without a preceding inversion");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> !rv_q && !pv_q)
    else $error("load accepted while products are in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_req.start |-> (state_q == S_DDIV || state_q == S_DRAIN))
    else $error("divider started from an unexpected state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   last_of_matrix_o |=> !result_strobe_o)
    else $error("result transfer after the last element of the matrix");

endmodule
